// ----- rtl/core/clr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_pkg
// shared types and constants of the clipped line rasterizer
// ----------------------------------------------------------------------------
package clr_pkg;

	// clip window registers are fixed at 12 bits
	localparam int CLIP_BITS = 12;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RST  = 12'd480;
	localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RST = 12'd120;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

	typedef enum logic {
		REG_CLIP_WIDTH  = 1'b0,
		REG_CLIP_HEIGHT = 1'b1
	} reg_idx_t;

	// commands from the word registers to the stepper
	typedef struct packed {
		logic load;
		logic step;
	} step_ctrl_t;

endpackage

// ----- rtl/core/clr_apb_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_apb_regs
// apb register file holding the clip window size
// ----------------------------------------------------------------------------
module clr_apb_regs import clr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output logic [CLIP_BITS-1:0]     clip_width,
	output logic [CLIP_BITS-1:0]     clip_height
);

	logic [CLIP_BITS-1:0] clip_width_q;
	logic [CLIP_BITS-1:0] clip_height_q;
	reg_idx_t             reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	// registers sit at word addresses, bit 2 picks one
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_width_q  <= CLIP_WIDTH_RST;
			clip_height_q <= CLIP_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CLIP_WIDTH:  clip_width_q  <= pwdata[CLIP_BITS-1:0];
				REG_CLIP_HEIGHT: clip_height_q <= pwdata[CLIP_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_CLIP_WIDTH:  prdata[CLIP_BITS-1:0] = clip_width_q;
			REG_CLIP_HEIGHT: prdata[CLIP_BITS-1:0] = clip_height_q;
			default: ;
		endcase
	end

	assign clip_width  = clip_width_q;
	assign clip_height = clip_height_q;

endmodule

// ----- rtl/core/clr_stepper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_stepper
// bresenham state, clip test and one-pixel advance per step
// ----------------------------------------------------------------------------
module clr_stepper import clr_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  step_ctrl_t                   ctrl,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	input  logic [CLIP_BITS-1:0]         clip_width,
	input  logic [CLIP_BITS-1:0]         clip_height,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         visible,
	output logic                         last,
	output logic                         busy
);

	localparam int DW = COORD_BITS + 1;   // delta width
	localparam int EW = COORD_BITS + 3;   // error term width
	localparam int CW = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [DW-1:0]                abs_dx_q, abs_dy_q;
	logic                         dir_x_neg_q, dir_y_neg_q;
	logic signed [EW-1:0]         err_q;
	logic                         busy_q;

	logic signed [DW-1:0] dx_raw, dy_raw;
	logic [DW-1:0]        dx_abs, dy_abs;
	logic signed [EW-1:0] err_init;
	logic signed [EW:0]   e2, dx_e, dy_e;
	logic                 step_x, step_y;
	logic signed [EW-1:0] err_next;
	logic [CW-1:0]        x_cmp, y_cmp, w_cmp, h_cmp;

	// load setup
	always_comb begin
		dx_raw   = DW'(x_end) - DW'(x_start);
		dy_raw   = DW'(y_end) - DW'(y_start);
		dx_abs   = dx_raw[DW-1] ? DW'(-dx_raw) : DW'(dx_raw);
		dy_abs   = dy_raw[DW-1] ? DW'(-dy_raw) : DW'(dy_raw);
		err_init = signed'(EW'(dx_abs)) - signed'(EW'(dy_abs));
	end

	// doubled-error test
	always_comb begin
		e2       = {err_q, 1'b0};
		dx_e     = signed'((EW+1)'(abs_dx_q));
		dy_e     = signed'((EW+1)'(abs_dy_q));
		step_x   = e2 > -dy_e;
		step_y   = e2 < dx_e;
		err_next = err_q - (step_x ? signed'(EW'(abs_dy_q)) : '0)
		                 + (step_y ? signed'(EW'(abs_dx_q)) : '0);
	end

	// clip window test
	always_comb begin
		x_cmp   = CW'(unsigned'(cur_x_q));
		y_cmp   = CW'(unsigned'(cur_y_q));
		w_cmp   = CW'(clip_width);
		h_cmp   = CW'(clip_height);
		visible = !cur_x_q[COORD_BITS-1] && (x_cmp < w_cmp) &&
		          !cur_y_q[COORD_BITS-1] && (y_cmp < h_cmp);
		last    = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			abs_dx_q    <= '0;
			abs_dy_q    <= '0;
			dir_x_neg_q <= 1'b0;
			dir_y_neg_q <= 1'b0;
			err_q       <= '0;
			busy_q      <= 1'b0;
		end else if (ctrl.load) begin
			cur_x_q     <= x_start;
			cur_y_q     <= y_start;
			end_x_q     <= x_end;
			end_y_q     <= y_end;
			abs_dx_q    <= dx_abs;
			abs_dy_q    <= dy_abs;
			dir_x_neg_q <= !(x_start < x_end);
			dir_y_neg_q <= !(y_start < y_end);
			err_q       <= err_init;
			busy_q      <= 1'b1;
		end else if (ctrl.step && busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				err_q <= err_next;
				if (step_x) begin
					cur_x_q <= dir_x_neg_q ? cur_x_q - COORD_BITS'(1)
					                       : cur_x_q + COORD_BITS'(1);
				end
				if (step_y) begin
					cur_y_q <= dir_y_neg_q ? cur_y_q - COORD_BITS'(1)
					                       : cur_y_q + COORD_BITS'(1);
				end
			end
		end
	end

	assign pixel_x = cur_x_q;
	assign pixel_y = cur_y_q;
	assign busy    = busy_q;

endmodule

// ----- rtl/core/clipped_line_rasterizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// bresenham line stepper with a clip window test
// ----------------------------------------------------------------------------
// A load word (op 0) latches both endpoints and sets up the deltas, step
// directions and error term; it gives no result. Each step word (op 1) while
// a line is active returns the current pixel with a visible flag for the
// clip window (0 <= x < clip_width, 0 <= y < clip_height) and a last flag at
// the end point, then advances one pixel. A step with no active line gives
// nothing, and a load replaces any line in progress. Each word is held in the
// input register; the edge that consumes it updates the stepper state and,
// for a step, loads the result register, so a word can be taken every
// cycle as long as the result side keeps up. The clip registers live at
// byte address 0 (width) and 4 (height) of the apb port and should be written
// only while no line is being drawn.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer import clr_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// apb configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [APB_ADDR_BITS-1:0]     paddr,
	input  logic [APB_DATA_BITS-1:0]     pwdata,
	output logic [APB_DATA_BITS-1:0]     prdata,
	output logic                         pready,
	// input words
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] x_start,
	input  logic signed [COORD_BITS-1:0] y_start,
	input  logic signed [COORD_BITS-1:0] x_end,
	input  logic signed [COORD_BITS-1:0] y_end,
	// result words
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic                         visible,
	output logic                         last
);

	logic [CLIP_BITS-1:0] clip_width, clip_height;

	// input register
	logic                         valid_s1;
	op_t                          op_s1;
	logic signed [COORD_BITS-1:0] x_start_s1, y_start_s1, x_end_s1, y_end_s1;

	// result register
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic                         visible_q, last_q;

	// stepper outputs
	logic signed [COORD_BITS-1:0] cur_x, cur_y;
	logic                         cur_vis, cur_last, busy;

	step_ctrl_t ctrl;
	logic       out_free;   // result register can take a word this cycle
	logic       emit;       // a pixel goes into the result register
	logic       adv_s1;     // the word in the input register is consumed

	clr_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.clip_width  (clip_width),
		.clip_height (clip_height)
	);

	// a load or an idle step never needs the result side
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		emit      = valid_s1 && (op_s1 == OP_STEP) && busy && out_free;
		adv_s1    = valid_s1 && ((op_s1 == OP_LOAD) || !busy || out_free);
		ctrl.load = valid_s1 && (op_s1 == OP_LOAD);
		ctrl.step = emit;
		in_ready  = !valid_s1 || adv_s1;
	end

	clr_stepper #(
		.COORD_BITS (COORD_BITS)
	) u_stepper (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.x_start     (x_start_s1),
		.y_start     (y_start_s1),
		.x_end       (x_end_s1),
		.y_end       (y_end_s1),
		.clip_width  (clip_width),
		.clip_height (clip_height),
		.pixel_x     (cur_x),
		.pixel_y     (cur_y),
		.visible     (cur_vis),
		.last        (cur_last),
		.busy        (busy)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op_t'(op);
			x_start_s1 <= x_start;
			y_start_s1 <= y_start;
			x_end_s1   <= x_end;
			y_end_s1   <= y_end;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q <= cur_x;
			pixel_y_q <= cur_y;
			visible_q <= cur_vis;
			last_q    <= cur_last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign visible   = visible_q;
	assign last      = last_q;

endmodule
